>>> rtl/core/rmt_pkg.sv
// Shared types, sizes and helpers for the range add / range max tree.
// No dependencies; used by every module of the block except rmt_ram.
package rmt_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_BITS   = 32;
    localparam int IDX_BITS     = $clog2(MAX_ELEMENTS);
    localparam int SIZE_BITS    = IDX_BITS + 1;
    localparam int NODE_DEPTH   = 2 * MAX_ELEMENTS;
    localparam int NODE_BITS    = $clog2(NODE_DEPTH);
    localparam int STACK_DEPTH  = IDX_BITS + 2;
    localparam int SP_BITS      = $clog2(STACK_DEPTH);
    localparam int WORD_BITS    = 2 * VALUE_BITS;

    typedef enum logic [1:0] {
        OP_ASSIGN = 2'd0,
        OP_ADD    = 2'd1,
        OP_QUERY  = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_ENTER,
        CMD_LEAF,
        CMD_PD0,
        CMD_PD1,
        CMD_PD2,
        CMD_POP,
        CMD_RESUME,
        CMD_PU0,
        CMD_PU1,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic skip;
        logic is_query;
        logic l_gt_r;
        logic covered;
        logic at_root;
        logic right_done;
        logic out_free;
    } t_dp_status;

    // Signed maximum of two values.
    function automatic logic [VALUE_BITS-1:0] vmax(input logic signed [VALUE_BITS-1:0] a,
                                                   input logic signed [VALUE_BITS-1:0] b);
        return (a >= b) ? a : b;
    endfunction

endpackage

>>> rtl/core/rmt_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/rmt_ctrl.sv
// Sequencer for the tree walk: issues one datapath command per cycle.
// Depends on rmt_pkg.
module rmt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  rmt_pkg::t_dp_status i_stat,
    output rmt_pkg::t_cmd       o_cmd,
    output logic                o_in_ready
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_ENTER,
        ST_LEAF,
        ST_PD0,
        ST_PD1,
        ST_PD2,
        ST_RET,
        ST_RESUME,
        ST_PU0,
        ST_PU1,
        ST_DONE
    } t_state;

    t_state        r_state;
    t_state        n_state;
    rmt_pkg::t_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = rmt_pkg::CMD_NONE;
        unique case (r_state)
            ST_CLEAR: begin
                n_cmd = rmt_pkg::CMD_CLEAR;
                if (i_stat.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = rmt_pkg::CMD_LOAD;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = i_stat.skip ? ST_IDLE : ST_ENTER;
            end
            ST_ENTER: begin
                n_cmd = rmt_pkg::CMD_ENTER;
                priority if (i_stat.l_gt_r) begin
                    n_state = ST_RET;
                end else if (i_stat.covered) begin
                    n_state = ST_LEAF;
                end else begin
                    n_state = ST_PD0;
                end
            end
            ST_LEAF: begin
                n_cmd   = rmt_pkg::CMD_LEAF;
                n_state = ST_RET;
            end
            ST_PD0: begin
                n_cmd   = rmt_pkg::CMD_PD0;
                n_state = ST_PD1;
            end
            ST_PD1: begin
                n_cmd   = rmt_pkg::CMD_PD1;
                n_state = ST_PD2;
            end
            ST_PD2: begin
                n_cmd   = rmt_pkg::CMD_PD2;
                n_state = ST_ENTER;
            end
            ST_RET: begin
                if (i_stat.at_root) begin
                    n_state = i_stat.is_query ? ST_DONE : ST_IDLE;
                end else begin
                    n_cmd   = rmt_pkg::CMD_POP;
                    n_state = ST_RESUME;
                end
            end
            ST_RESUME: begin
                n_cmd = rmt_pkg::CMD_RESUME;
                priority if (!i_stat.right_done) begin
                    n_state = ST_ENTER;
                end else if (i_stat.is_query) begin
                    n_state = ST_RET;
                end else begin
                    n_state = ST_PU0;
                end
            end
            ST_PU0: begin
                n_cmd   = rmt_pkg::CMD_PU0;
                n_state = ST_PU1;
            end
            ST_PU1: begin
                n_cmd   = rmt_pkg::CMD_PU1;
                n_state = ST_RET;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_cmd   = rmt_pkg::CMD_OUT;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = n_cmd;
    assign o_in_ready = (r_state == ST_IDLE);

endmodule

>>> rtl/core/rmt_dp.sv
// Datapath: size register, node RAM, walk stack and result register.
// Depends on rmt_pkg and rmt_ram.
module rmt_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rmt_pkg::t_cmd                         i_cmd,
    input  logic                                  i_cfg_we,
    input  logic [rmt_pkg::SIZE_BITS-1:0]         i_cfg_data,
    input  logic [1:0]                            i_op,
    input  logic [rmt_pkg::IDX_BITS-1:0]          i_range_low,
    input  logic [rmt_pkg::IDX_BITS-1:0]          i_range_high,
    input  logic signed [rmt_pkg::VALUE_BITS-1:0] i_value,
    input  logic                                  i_out_ready,
    output rmt_pkg::t_dp_status                   o_stat,
    output logic                                  o_out_valid,
    output logic signed [rmt_pkg::VALUE_BITS-1:0] o_range_max,
    output logic                                  o_range_empty
);

    localparam int VB = rmt_pkg::VALUE_BITS;
    localparam int IB = rmt_pkg::IDX_BITS;
    localparam int NB = rmt_pkg::NODE_BITS;
    localparam int SB = rmt_pkg::SIZE_BITS;
    localparam int PB = rmt_pkg::SP_BITS;
    localparam int STK = rmt_pkg::STACK_DEPTH;
    localparam logic [VB-1:0] NEG = {1'b1, {(VB-1){1'b0}}};

    logic [SB-1:0]  r_size;
    logic [NB-1:0]  r_clr;
    rmt_pkg::t_op   r_op;
    logic [VB-1:0]  r_val;
    logic           r_empty;
    logic           r_skip;
    logic [VB-1:0]  r_res;
    logic [VB-1:0]  r_pend;
    logic [VB-1:0]  r_cmax;
    logic [PB-1:0]  r_d;
    logic           r_out_valid;
    logic [VB-1:0]  r_out_max;
    logic           r_out_empty;

    // Walk stack, one frame per tree level.
    logic [NB-1:0]  r_v   [STK];
    logic [IB-1:0]  r_tl  [STK];
    logic [IB-1:0]  r_tr  [STK];
    logic [IB-1:0]  r_l   [STK];
    logic [IB-1:0]  r_r   [STK];
    logic           r_ph  [STK];
    logic [VB-1:0]  r_acc [STK];

    logic [NB-1:0]  cur_v;
    logic [IB-1:0]  cur_tl, cur_tr, cur_l, cur_r;
    logic           cur_ph;
    logic [VB-1:0]  cur_acc;
    logic [IB:0]    mid_sum;
    logic [IB-1:0]  tm, tm1;
    logic [NB-1:0]  lchild, rchild;
    logic [SB-1:0]  n_elems;
    logic [IB-1:0]  n_last;
    logic [IB-1:0]  hi_clip;
    logic [PB-1:0]  d_up;

    logic              ram_we;
    logic [NB-1:0]     ram_waddr, ram_raddr;
    logic [2*VB-1:0]   ram_wdata, ram_rdata;
    logic [VB-1:0]     rd_max, rd_pend;

    assign cur_v   = r_v[r_d];
    assign cur_tl  = r_tl[r_d];
    assign cur_tr  = r_tr[r_d];
    assign cur_l   = r_l[r_d];
    assign cur_r   = r_r[r_d];
    assign cur_ph  = r_ph[r_d];
    assign cur_acc = r_acc[r_d];

    assign mid_sum = {1'b0, cur_tl} + {1'b0, cur_tr};
    assign tm      = mid_sum[IB:1];
    assign tm1     = tm + 1'b1;
    assign lchild  = {cur_v[NB-2:0], 1'b0};
    assign rchild  = {cur_v[NB-2:0], 1'b1};
    assign d_up    = r_d + 1'b1;

    // Size clamp: zero acts as one, anything above the capacity as the capacity.
    always_comb begin
        priority if (r_size == '0) begin
            n_elems = SB'(1);
        end else if (r_size > SB'(rmt_pkg::MAX_ELEMENTS)) begin
            n_elems = SB'(rmt_pkg::MAX_ELEMENTS);
        end else begin
            n_elems = r_size;
        end
    end
    assign n_last  = IB'(n_elems - 1'b1);
    assign hi_clip = (i_range_high < n_last) ? i_range_high : n_last;

    assign rd_max  = ram_rdata[2*VB-1:VB];
    assign rd_pend = ram_rdata[VB-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_v;
        ram_wdata = '0;
        ram_raddr = cur_v;
        unique case (i_cmd)
            rmt_pkg::CMD_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            rmt_pkg::CMD_LEAF: begin
                ram_we = (r_op != rmt_pkg::OP_QUERY);
                if (r_op == rmt_pkg::OP_ASSIGN) begin
                    ram_wdata = {r_val, rd_pend};
                end else begin
                    ram_wdata = {rd_max + r_val, rd_pend + r_val};
                end
            end
            rmt_pkg::CMD_PD0: begin
                ram_we    = 1'b1;
                ram_wdata = {rd_max, {VB{1'b0}}};
                ram_raddr = lchild;
            end
            rmt_pkg::CMD_PD1: begin
                ram_we    = 1'b1;
                ram_waddr = lchild;
                ram_wdata = {rd_max + r_pend, rd_pend + r_pend};
                ram_raddr = rchild;
            end
            rmt_pkg::CMD_PD2: begin
                ram_we    = 1'b1;
                ram_waddr = rchild;
                ram_wdata = {rd_max + r_pend, rd_pend + r_pend};
            end
            rmt_pkg::CMD_RESUME: begin
                ram_raddr = lchild;
            end
            rmt_pkg::CMD_PU0: begin
                ram_raddr = rchild;
            end
            rmt_pkg::CMD_PU1: begin
                ram_we    = 1'b1;
                ram_wdata = {rmt_pkg::vmax(r_cmax, rd_max), {VB{1'b0}}};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    rmt_ram #(
        .WIDTH (2 * VB),
        .DEPTH (rmt_pkg::NODE_DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SB'(rmt_pkg::MAX_ELEMENTS);
            r_clr       <= '0;
            r_d         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            // A new result may be loaded in the same cycle the old one is taken.
            if (i_cmd == rmt_pkg::CMD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd)
                rmt_pkg::CMD_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                rmt_pkg::CMD_LOAD: begin
                    r_op    <= rmt_pkg::t_op'(i_op);
                    r_val   <= i_value;
                    r_empty <= (i_range_low > i_range_high);
                    r_skip  <= (i_op == rmt_pkg::OP_RSVD) ||
                               ((i_op == rmt_pkg::OP_ASSIGN) &&
                                ({1'b0, i_range_low} >= n_elems));
                    r_d     <= '0;
                    r_v[0]  <= NB'(1);
                    r_tl[0] <= '0;
                    r_tr[0] <= n_last;
                    r_l[0]  <= i_range_low;
                    r_r[0]  <= (i_op == rmt_pkg::OP_ASSIGN) ? i_range_low : hi_clip;
                    r_ph[0] <= 1'b0;
                end
                rmt_pkg::CMD_ENTER: begin
                    r_res <= NEG;
                end
                rmt_pkg::CMD_LEAF: begin
                    if (r_op == rmt_pkg::OP_QUERY) begin
                        r_res <= rd_max;
                    end
                end
                rmt_pkg::CMD_PD0: begin
                    r_pend <= rd_pend;
                end
                rmt_pkg::CMD_PD2: begin
                    r_v[d_up]  <= lchild;
                    r_tl[d_up] <= cur_tl;
                    r_tr[d_up] <= tm;
                    r_l[d_up]  <= cur_l;
                    r_r[d_up]  <= (cur_r < tm) ? cur_r : tm;
                    r_ph[d_up] <= 1'b0;
                    r_d        <= d_up;
                end
                rmt_pkg::CMD_POP: begin
                    r_d <= r_d - 1'b1;
                end
                rmt_pkg::CMD_RESUME: begin
                    if (!cur_ph) begin
                        r_acc[r_d] <= r_res;
                        r_ph[r_d]  <= 1'b1;
                        r_v[d_up]  <= rchild;
                        r_tl[d_up] <= tm1;
                        r_tr[d_up] <= cur_tr;
                        r_l[d_up]  <= (cur_l > tm1) ? cur_l : tm1;
                        r_r[d_up]  <= cur_r;
                        r_ph[d_up] <= 1'b0;
                        r_d        <= d_up;
                    end else begin
                        r_res <= rmt_pkg::vmax(cur_acc, r_res);
                    end
                end
                rmt_pkg::CMD_PU0: begin
                    r_cmax <= rd_max;
                end
                rmt_pkg::CMD_OUT: begin
                    r_out_max   <= r_res;
                    r_out_empty <= r_empty;
                end
                default: begin
                    r_d <= r_d;
                end
            endcase
        end
    end

    assign o_stat.clear_done = (r_clr == NB'(rmt_pkg::NODE_DEPTH - 1));
    assign o_stat.skip       = r_skip;
    assign o_stat.is_query   = (r_op == rmt_pkg::OP_QUERY);
    assign o_stat.l_gt_r     = (cur_l > cur_r);
    assign o_stat.covered    = (cur_l == cur_tl) && (cur_r == cur_tr);
    assign o_stat.at_root    = (r_d == '0);
    assign o_stat.right_done = cur_ph;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_range_max   = r_out_max;
    assign o_range_empty = r_out_empty;

`ifndef SYNTHESIS
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d < PB'(STK))
        else $error("walk stack overflow");

    a_left_child_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == rmt_pkg::CMD_PD2) |=> (r_v[r_d][0] == 1'b0))
        else $error("left child pushed with odd node index");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == rmt_pkg::CMD_OUT) |=> r_out_valid)
        else $error("result not registered after output command");
`endif

endmodule

>>> rtl/core/range_add_range_max_tree.sv
// Range add / range max segment tree top level; depends on rmt_pkg, rmt_ctrl and rmt_dp.
// A point assign walks the single path from the root down to its leaf; range add and
// range max visit every node whose range meets the word's range, stopping at nodes that
// are empty or fully covered and splitting the rest further.
// Throughput is one word at a time; the node RAM serves one read and one write a cycle.
// Reset (synchronous, active low) sets the size to 1024 and clears the node RAM.
module range_add_range_max_tree (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rmt_pkg::SIZE_BITS-1:0]         i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_op,
    input  logic [rmt_pkg::IDX_BITS-1:0]          i_range_low,
    input  logic [rmt_pkg::IDX_BITS-1:0]          i_range_high,
    input  logic signed [rmt_pkg::VALUE_BITS-1:0] i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [rmt_pkg::VALUE_BITS-1:0] o_range_max,
    output logic                                  o_range_empty
);

    // The controller walks the segment tree depth first with an explicit stack held in
    // the datapath. Each node visit pushes pending additions to both children before
    // descending, and updates rebuild the node maximum on the way back up.
    rmt_pkg::t_cmd       cmd;
    rmt_pkg::t_dp_status stat;

    rmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    // The datapath owns the node RAM and a result register, so a finished query
    // word can wait for the consumer while the next input word is accepted.
    rmt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_value       (i_value),
        .i_out_ready   (i_out_ready),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_range_max   (o_range_max),
        .o_range_empty (o_range_empty)
    );

endmodule

>>> sim/range_add_range_max_tree_test.sv
// Self-checking testbench for range_add_range_max_tree: a lazy segment tree with
// point assign, range add and range max query. Depends on rmt_pkg and the RTL only.
module range_add_range_max_tree_test;

    localparam int SHADOW_NODES = 4 * rmt_pkg::MAX_ELEMENTS;
    localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;
    // A range word visits at most a few dozen nodes.
    localparam int DRAIN_CYCLES = 800;

    typedef struct packed {
        logic signed [31:0] peak;
        logic               empty;
    } t_answer;

    // The scoreboard keeps a shadow copy of the tree, runs every accepted word
    // through it, and queues the answer that each query must produce.
    class tree_scoreboard;
        logic signed [31:0] shadow_max [SHADOW_NODES];
        logic signed [31:0] shadow_add [SHADOW_NODES];
        logic [rmt_pkg::SIZE_BITS-1:0] size_reg;
        t_answer answers [$];
        int errors;
        int queries_seen;

        function new();
            foreach (shadow_max[i]) begin
                shadow_max[i] = 0;
                shadow_add[i] = 0;
            end
            size_reg = 11'd1024;
            errors = 0;
            queries_seen = 0;
        endfunction

        function logic signed [31:0] bigger(logic signed [31:0] a, logic signed [31:0] b);
            return (a >= b) ? a : b;
        endfunction

        function logic signed [31:0] node_val(int v);
            return (v < SHADOW_NODES) ? shadow_max[v] : 32'sd0;
        endfunction

        function void bump(int v, logic signed [31:0] amt);
            if (v < SHADOW_NODES) begin
                shadow_max[v] = shadow_max[v] + amt;
                shadow_add[v] = shadow_add[v] + amt;
            end
        endfunction

        // Hands the parent's deferred addition on to both children.
        function void push_pending(int v);
            if (v >= SHADOW_NODES) return;
            bump(2 * v, shadow_add[v]);
            bump(2 * v + 1, shadow_add[v]);
            shadow_add[v] = 0;
        endfunction

        function void refresh(int v);
            if (v < SHADOW_NODES) shadow_max[v] = bigger(node_val(2 * v), node_val(2 * v + 1));
        endfunction

        function void set_leaf(int v, int tl, int tr, int pos, logic signed [31:0] val);
            int tm;
            if (tl == tr) begin
                if (v < SHADOW_NODES) shadow_max[v] = val;
                return;
            end
            tm = (tl + tr) / 2;
            push_pending(v);
            if (pos <= tm) set_leaf(2 * v, tl, tm, pos, val);
            else set_leaf(2 * v + 1, tm + 1, tr, pos, val);
            refresh(v);
        endfunction

        function void add_span(int v, int tl, int tr, int l, int r, logic signed [31:0] amt);
            int tm;
            if (l > r) return;
            if (l == tl && r == tr) begin
                bump(v, amt);
                return;
            end
            tm = (tl + tr) / 2;
            push_pending(v);
            add_span(2 * v, tl, tm, l, (r < tm) ? r : tm, amt);
            add_span(2 * v + 1, tm + 1, tr, (l > tm + 1) ? l : tm + 1, r, amt);
            refresh(v);
        endfunction

        function logic signed [31:0] max_span(int v, int tl, int tr, int l, int r);
            int tm;
            if (l > r) return MOST_NEG;
            if (l <= tl && tr <= r) return node_val(v);
            tm = (tl + tr) / 2;
            push_pending(v);
            return bigger(max_span(2 * v, tl, tm, l, (r < tm) ? r : tm),
                          max_span(2 * v + 1, tm + 1, tr, (l > tm + 1) ? l : tm + 1, r));
        endfunction

        function void note_word(rmt_pkg::t_op op, int lo, int hi, logic signed [31:0] val);
            int n;
            int hc;
            t_answer ans;
            n = (size_reg == 0) ? 1 :
                ((size_reg > rmt_pkg::MAX_ELEMENTS) ? rmt_pkg::MAX_ELEMENTS : size_reg);
            hc = (hi < n - 1) ? hi : n - 1;
            case (op)
                rmt_pkg::OP_ASSIGN: begin
                    if (lo < n) set_leaf(1, 0, n - 1, lo, val);
                end
                rmt_pkg::OP_ADD: begin
                    add_span(1, 0, n - 1, lo, hc, val);
                end
                rmt_pkg::OP_QUERY: begin
                    ans.peak = max_span(1, 0, n - 1, lo, hc);
                    ans.empty = (lo > hi);
                    answers.push_back(ans);
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic signed [31:0] peak, logic empty);
            t_answer want;
            queries_seen++;
            if (answers.size() == 0) begin
                $display("%0t: unexpected result max=%0d empty=%0b", $time, peak, empty);
                errors++;
                return;
            end
            want = answers.pop_front();
            if (peak !== want.peak) begin
                $display("%0t: range_max expected %0d actual %0d", $time, want.peak, peak);
                errors++;
            end
            if (empty !== want.empty) begin
                $display("%0t: range_empty expected %0b actual %0b", $time, want.empty, empty);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [rmt_pkg::SIZE_BITS-1:0]  i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [1:0]                     i_op = 2'd0;
    logic [rmt_pkg::IDX_BITS-1:0]   i_range_low = '0;
    logic [rmt_pkg::IDX_BITS-1:0]   i_range_high = '0;
    logic signed [31:0]             i_value = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic signed [31:0]             o_range_max;
    logic                           o_range_empty;

    tree_scoreboard sb = new();
    // When set, the matching side never idles, giving back-to-back stretches.
    bit send_eager = 1'b0;
    bit take_eager = 1'b0;
    int words_sent = 0;

    always #5 i_clk = ~i_clk;

    range_add_range_max_tree dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_range_max  (o_range_max),
        .o_range_empty(o_range_empty)
    );

    // Presents one word after a random gap and holds it until the block takes it.
    // Valid is only lowered when a gap follows, so it never toggles within a step.
    task automatic send_word(rmt_pkg::t_op op, int lo, int hi, logic signed [31:0] val);
        int gap;
        gap = send_eager ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_range_low  <= lo[rmt_pkg::IDX_BITS-1:0];
        i_range_high <= hi[rmt_pkg::IDX_BITS-1:0];
        i_value      <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_word(op, lo, hi, val);
        words_sent++;
    endtask

    // The size register may only change with the block idle, so wait until every
    // query has answered and then give any trailing update time to finish.
    task automatic set_size(int sz);
        i_in_valid <= 1'b0;
        while (sb.answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= sz[rmt_pkg::SIZE_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.size_reg = sz[rmt_pkg::SIZE_BITS-1:0];
        @(posedge i_clk);
    endtask

    // Mostly in-range indices so the traffic exercises real tree paths; now and then
    // anything the field allows, which covers clipping and the upper index bits.
    function automatic int pick_index(int n);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
        return $urandom_range(0, n - 1);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return $signed($urandom_range(0, 200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_words(int n, int count);
        int lo, hi, tmp, pick;
        rmt_pkg::t_op op;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            op = (pick < 30) ? rmt_pkg::OP_ASSIGN :
                 (pick < 60) ? rmt_pkg::OP_ADD :
                 (pick < 96) ? rmt_pkg::OP_QUERY : rmt_pkg::OP_RSVD;
            lo = pick_index(n);
            hi = pick_index(n);
            // Most ranges are well formed; a few are left reversed on purpose.
            if (lo > hi && $urandom_range(0, 7) != 0) begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
            send_word(op, lo, hi, pick_value());
        end
    endtask

    // Sizes written over the run, including zero and the out-of-range extreme.
    int sizes [9] = '{1, 2, 1024, 0, 7, 2047, 100, 513, 33};

    initial begin
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block clears its node store after reset and holds ready low meanwhile.
        do @(posedge i_clk); while (o_in_ready !== 1'b1);

        // Directed words at the full size of 1024.
        send_word(rmt_pkg::OP_QUERY, 0, 1023, 0);
        send_word(rmt_pkg::OP_ASSIGN, 0, 0, MOST_POS);
        send_word(rmt_pkg::OP_ASSIGN, 1023, 0, MOST_NEG);
        send_word(rmt_pkg::OP_QUERY, 0, 1023, 0);
        send_word(rmt_pkg::OP_QUERY, 1023, 1023, 0);
        send_word(rmt_pkg::OP_ADD, 0, 1023, 32'sd1);
        send_word(rmt_pkg::OP_QUERY, 0, 0, 0);
        send_word(rmt_pkg::OP_QUERY, 1, 1023, 0);
        send_word(rmt_pkg::OP_ADD, 5, 3, 32'sd99);
        send_word(rmt_pkg::OP_QUERY, 5, 3, 0);
        send_word(rmt_pkg::OP_RSVD, 0, 1023, MOST_POS);
        send_word(rmt_pkg::OP_ADD, 300, 700, MOST_NEG);
        send_word(rmt_pkg::OP_QUERY, 250, 750, 0);
        send_word(rmt_pkg::OP_QUERY, 512, 511, 0);
        random_words(1024, 60);

        foreach (sizes[k]) begin
            set_size(sizes[k]);
            n = (sizes[k] == 0) ? 1 :
                ((sizes[k] > rmt_pkg::MAX_ELEMENTS) ? rmt_pkg::MAX_ELEMENTS : sizes[k]);
            send_eager = (k % 3 == 1);
            take_eager = (k % 4 == 2);
            // Clipping cases: indices up to 1023, past the array whenever the size in force is below 1024.
            send_word(rmt_pkg::OP_ASSIGN, 1023, 0, 32'sd77);
            send_word(rmt_pkg::OP_QUERY, n - 1, 1023, 0);
            send_word(rmt_pkg::OP_ADD, 1000, 1023, 32'sd5);
            send_word(rmt_pkg::OP_QUERY, 1023, 1023, 0);
            random_words(n, 145);
        end

        i_in_valid <= 1'b0;
        while (sb.answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d words over %0d sizes, %0d query results checked.",
                 words_sent, 10, sb.queries_seen);
        if (sb.errors == 0 && sb.answers.size() == 0) begin
            $display("range_add_range_max_tree regression: pass");
        end else begin
            $display("range_add_range_max_tree regression: fail");
        end
        $finish;
    end

    // Receiving side: a random stall per result, then a wait for the handshake.
    initial begin
        int stall;
        forever begin
            stall = take_eager ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_word(o_range_max, o_range_empty);
        end
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #50_000_000;
        $display("range_add_range_max_tree regression: fail");
        $finish;
    end

endmodule
